// File: rtl/u8u16_pkg.sv
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
package u8u16_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  localparam logic [15:0] REPL_CHAR   = 16'hFFFD;
  localparam logic [15:0] HIGH_SURR   = 16'hD800;
  localparam logic [15:0] LOW_SURR    = 16'hDC00;
  localparam logic [20:0] SURR_FIRST  = 21'h00D800;
  localparam logic [20:0] SURR_LAST   = 21'h00DFFF;
  localparam logic [20:0] POINT_LIMIT = 21'h110000;
  localparam logic [20:0] PLANE1_BASE = 21'h010000;

  // What the back end has to emit for one queued request.
  typedef enum logic [1:0] {
    KIND_BMP,
    KIND_PAIR,
    KIND_REPL
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [19:0] value;  // BMP unit in [15:0], or code point minus 0x10000
    logic        eos;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// File: rtl/u8u16_front.sv
// Front end: accepts UTF-8 bytes, tracks open sequences and classifies code points.
module u8u16_front import u8u16_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [7:0]  byte_in,
  input  logic        end_of_string,
  output logic        push,
  output entry_t      push_entry
);

  logic [1:0]  bytes_pending, bytes_pending_next;
  logic [20:0] partial_point, partial_point_next;
  logic        produce;
  logic        open_seq;
  logic        is_cont;
  logic [20:0] cp;
  logic [19:0] cp_off;

  assign is_cont = (byte_in[7:6] == 2'b10);
  assign cp      = {partial_point[14:0], byte_in[5:0]};
  assign cp_off  = cp[19:0] - PLANE1_BASE[19:0];

  always_comb begin
    bytes_pending_next = bytes_pending;
    partial_point_next = partial_point;
    produce            = 1'b0;
    open_seq           = 1'b0;
    push_entry.kind    = KIND_REPL;
    push_entry.value   = '0;
    push_entry.eos     = end_of_string;
    if (bytes_pending == 2'd0) begin
      priority if (is_cont) begin
        produce = 1'b1;
      end else if (!byte_in[7]) begin
        produce          = 1'b1;
        push_entry.kind  = KIND_BMP;
        push_entry.value = {12'b0, byte_in};
      end else if (byte_in[7:5] == 3'b110) begin
        bytes_pending_next = 2'd1;
        partial_point_next = {16'b0, byte_in[4:0]};
        open_seq           = 1'b1;
      end else if (byte_in[7:4] == 4'b1110) begin
        bytes_pending_next = 2'd2;
        partial_point_next = {17'b0, byte_in[3:0]};
        open_seq           = 1'b1;
      end else if (byte_in[7:3] == 5'b11110) begin
        bytes_pending_next = 2'd3;
        partial_point_next = {18'b0, byte_in[2:0]};
        open_seq           = 1'b1;
      end else begin
        produce = 1'b1;
      end
    end else if (!is_cont) begin
      // Abandon the sequence; the byte is consumed.
      bytes_pending_next = 2'd0;
      partial_point_next = '0;
      produce            = 1'b1;
    end else begin
      bytes_pending_next = bytes_pending - 2'd1;
      if (bytes_pending == 2'd1) begin
        partial_point_next = '0;
        produce            = 1'b1;
        priority if ((cp >= SURR_FIRST && cp <= SURR_LAST) || cp >= POINT_LIMIT) begin
          push_entry.kind = KIND_REPL;
        end else if (cp[20:16] == 5'd0) begin
          push_entry.kind  = KIND_BMP;
          push_entry.value = {4'b0, cp[15:0]};
        end else begin
          push_entry.kind  = KIND_PAIR;
          push_entry.value = cp_off;
        end
      end else begin
        partial_point_next = cp;
        open_seq           = 1'b1;
      end
    end
    // String ends with a sequence still open.
    if (open_seq && end_of_string) begin
      bytes_pending_next = 2'd0;
      partial_point_next = '0;
      produce            = 1'b1;
      push_entry.kind    = KIND_REPL;
      push_entry.value   = '0;
    end
  end

  assign push = accept && produce;

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_pending <= 2'd0;
      partial_point <= '0;
    end else if (accept) begin
      bytes_pending <= bytes_pending_next;
      partial_point <= partial_point_next;
    end
  end

endmodule

// File: rtl/u8u16_queue.sv
// Short request queue between the front and back ends.
module u8u16_queue import u8u16_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  entry_t    push_entry,
  input  logic      pop,
  output entry_t    head,
  output q_status_t status
);

  entry_t             slots [QueueDepth];
  logic [QPtrW-1:0]   wr_ptr;
  logic [QPtrW-1:0]   rd_ptr;
  logic [QCntW-1:0]   count;

  assign status.full  = (count == QCntW'(QueueDepth));
  assign status.empty = (count == '0);
  assign head         = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/u8u16_back.sv
// Back end: expands queued requests into UTF-16 units behind an output register.
module u8u16_back import u8u16_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  entry_t      head,
  input  q_status_t   status,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] code_unit,
  output logic        last_of_run,
  output logic        string_done,
  output logic        replaced
);

  logic        load;
  logic        take;
  logic        second, second_next;
  logic [15:0] unit_next;
  logic        last_next, done_next, repl_next;

  assign load = !out_valid || !out_stall;
  assign take = load && !status.empty;
  assign pop  = take && ((head.kind != KIND_PAIR) || second);

  always_comb begin
    second_next = second;
    unit_next   = REPL_CHAR;
    last_next   = 1'b1;
    done_next   = head.eos;
    repl_next   = 1'b1;
    unique case (head.kind)
      KIND_BMP: begin
        unit_next = head.value[15:0];
        repl_next = 1'b0;
      end
      KIND_PAIR: begin
        repl_next = 1'b0;
        if (!second) begin
          unit_next   = HIGH_SURR | {6'b0, head.value[19:10]};
          last_next   = 1'b0;
          done_next   = 1'b0;
          second_next = take;
        end else begin
          unit_next   = LOW_SURR | {6'b0, head.value[9:0]};
          second_next = !take;
        end
      end
      default: begin
        unit_next = REPL_CHAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      second    <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= !status.empty;
      end
      if (take) begin
        second <= second_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      code_unit   <= unit_next;
      last_of_run <= last_next;
      string_done <= done_next;
      replaced    <= repl_next;
    end
  end

endmodule

// File: rtl/utf8_to_utf16_transcoder_unit.sv
// Top level of the UTF-8 to UTF-16 transcoder.
//
// Takes one UTF-8 byte per request and emits UTF-16 code units, one byte
// accepted per cycle while the queue has room. The front end tracks the
// open sequence and turns each byte into at most one request (a BMP unit,
// a surrogate pair or U+FFFD standing for malformed input); a four-entry
// queue hands requests to the back end, which expands a pair into a high
// and a low surrogate unit and holds each unit in an output register.
// Sustained rate is one byte per cycle while the output is not stalled,
// set by the front end's combinational decode; a byte that closes a
// four-byte sequence yields two units, which the three bytes before it,
// producing nothing, leave room for. in_stall rises only while the queue is full.
// Malformed input (stray continuation, lead bytes F8..FF, a broken or
// unfinished sequence, decoded surrogates, values of 0x110000 and above)
// yields U+FFFD with replaced set; overlong forms decode as written.
module utf8_to_utf16_transcoder_unit import u8u16_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  byte_in,
  input  logic        end_of_string,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] code_unit,
  output logic        last_of_run,
  output logic        string_done,
  output logic        replaced
);

  logic      accept;
  logic      push;
  logic      pop;
  entry_t    push_entry;
  entry_t    head;
  q_status_t status;

  // Hold off bytes only while the queue has no free slot.
  assign in_stall = status.full;
  assign accept   = in_valid && !in_stall;

  u8u16_front u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .byte_in       (byte_in),
    .end_of_string (end_of_string),
    .push          (push),
    .push_entry    (push_entry)
  );

  u8u16_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .status     (status)
  );

  u8u16_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .status      (status),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .code_unit   (code_unit),
    .last_of_run (last_of_run),
    .string_done (string_done),
    .replaced    (replaced)
  );

endmodule

// File: dv/utf8_to_utf16_transcoder_unit_test.sv
// Self-checking testbench for the UTF-8 to UTF-16 transcoder unit.
module utf8_to_utf16_transcoder_unit_test import u8u16_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit    = 200_000;
  localparam int DrainCycles   = 20;
  localparam int BytesPerPhase = 375;
  localparam int ReportLimit   = 10;

  // One UTF-16 unit as it leaves the block.
  typedef struct packed {
    logic [15:0] unit;
    logic        last;
    logic        done;
    logic        repl;
  } code_unit_t;

  // One directed request. When typed is set, the expected unit is given in
  // the row itself; otherwise the decoder model works it out.
  typedef struct {
    logic [7:0]  b;
    logic        eos;
    logic        typed;
    logic [15:0] unit;
    logic        last;
    logic        done;
    logic        repl;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  byte_in = 8'h00;
  logic        end_of_string = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] code_unit;
  logic        last_of_run;
  logic        string_done;
  logic        replaced;

  // Decoder model state: continuation bytes still owed and the partial point.
  logic [1:0]  seq_pending = 2'd0;
  logic [20:0] seq_point = 21'd0;

  code_unit_t  expected_units [$];
  int          failures = 0;
  int          cycles = 0;
  int          bytes_sent = 0;
  int          in_idle_pct = 7;
  int          out_stall_pct = 88;

  // Expectation carried by the request now on the bus.
  logic        row_typed = 1'b0;
  code_unit_t  row_want = '0;

  // Directed walk: extremes, stray and invalid bytes, an overlong form, the
  // largest valid point as a pair, a broken sequence, a string cut short,
  // an encoded surrogate and the largest out-of-range value.
  stim_row_t directed_rows [24] = '{
    '{8'h00, 1'b0, 1'b1, 16'h0000,  1'b1, 1'b0, 1'b0},
    '{8'h7F, 1'b1, 1'b1, 16'h007F,  1'b1, 1'b1, 1'b0},
    '{8'h80, 1'b0, 1'b1, REPL_CHAR, 1'b1, 1'b0, 1'b1},
    '{8'hFF, 1'b0, 1'b1, REPL_CHAR, 1'b1, 1'b0, 1'b1},
    '{8'hC0, 1'b0, 1'b0, 16'h0000,  1'b0, 1'b0, 1'b0},
    '{8'h80, 1'b0, 1'b0, 16'h0000,  1'b0, 1'b0, 1'b0},
    '{8'hE2, 1'b0, 1'b0, 16'h0000,  1'b0, 1'b0, 1'b0},
    '{8'h82, 1'b0, 1'b0, 16'h0000,  1'b0, 1'b0, 1'b0},
    '{8'hAC, 1'b1, 1'b0, 16'h0000,  1'b0, 1'b0, 1'b0},
    '{8'hF4, 1'b0, 1'b0, 16'h0000,  1'b0, 1'b0, 1'b0},
    '{8'h8F, 1'b0, 1'b0, 16'h0000,  1'b0, 1'b0, 1'b0},
    '{8'hBF, 1'b0, 1'b0, 16'h0000,  1'b0, 1'b0, 1'b0},
    '{8'hBF, 1'b0, 1'b0, 16'h0000,  1'b0, 1'b0, 1'b0},
    '{8'hC3, 1'b0, 1'b0, 16'h0000,  1'b0, 1'b0, 1'b0},
    '{8'h41, 1'b0, 1'b1, REPL_CHAR, 1'b1, 1'b0, 1'b1},
    '{8'hE2, 1'b0, 1'b0, 16'h0000,  1'b0, 1'b0, 1'b0},
    '{8'h82, 1'b1, 1'b1, REPL_CHAR, 1'b1, 1'b1, 1'b1},
    '{8'hED, 1'b0, 1'b0, 16'h0000,  1'b0, 1'b0, 1'b0},
    '{8'hA0, 1'b0, 1'b0, 16'h0000,  1'b0, 1'b0, 1'b0},
    '{8'h80, 1'b0, 1'b1, REPL_CHAR, 1'b1, 1'b0, 1'b1},
    '{8'hF7, 1'b0, 1'b0, 16'h0000,  1'b0, 1'b0, 1'b0},
    '{8'hBF, 1'b0, 1'b0, 16'h0000,  1'b0, 1'b0, 1'b0},
    '{8'hBF, 1'b0, 1'b0, 16'h0000,  1'b0, 1'b0, 1'b0},
    '{8'hBF, 1'b1, 1'b1, REPL_CHAR, 1'b1, 1'b1, 1'b1}
  };

  utf8_to_utf16_transcoder_unit dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .byte_in      (byte_in),
    .end_of_string(end_of_string),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .code_unit    (code_unit),
    .last_of_run  (last_of_run),
    .string_done  (string_done),
    .replaced     (replaced)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Queue the units that a finished code point turns into.
  function automatic void emit_point(input logic [20:0] point, input logic eos);
    logic [20:0] offset;
    if ((point >= SURR_FIRST && point <= SURR_LAST) || point >= POINT_LIMIT) begin
      expected_units.push_back('{REPL_CHAR, 1'b1, eos, 1'b1});
    end else if (point <= 21'h00FFFF) begin
      expected_units.push_back('{point[15:0], 1'b1, eos, 1'b0});
    end else begin
      offset = point - PLANE1_BASE;
      expected_units.push_back('{HIGH_SURR | {6'd0, offset[19:10]}, 1'b0, 1'b0, 1'b0});
      expected_units.push_back('{LOW_SURR | {6'd0, offset[9:0]}, 1'b1, eos, 1'b0});
    end
  endfunction

  // Advance the decoder model by one accepted byte and queue what it emits.
  function automatic void decode_byte(input logic [7:0] b, input logic eos);
    if (seq_pending == 2'd0) begin
      if (b[7:6] == 2'b10) begin
        expected_units.push_back('{REPL_CHAR, 1'b1, eos, 1'b1});
      end else if (!b[7]) begin
        expected_units.push_back('{{8'h00, b}, 1'b1, eos, 1'b0});
      end else if (b[7:5] == 3'b110) begin
        seq_pending = 2'd1;
        seq_point   = {16'd0, b[4:0]};
      end else if (b[7:4] == 4'b1110) begin
        seq_pending = 2'd2;
        seq_point   = {17'd0, b[3:0]};
      end else if (b[7:3] == 5'b11110) begin
        seq_pending = 2'd3;
        seq_point   = {18'd0, b[2:0]};
      end else begin
        expected_units.push_back('{REPL_CHAR, 1'b1, eos, 1'b1});
      end
    end else if (b[7:6] != 2'b10) begin
      // Drop the open sequence; the breaking byte itself is consumed.
      seq_pending = 2'd0;
      seq_point   = 21'd0;
      expected_units.push_back('{REPL_CHAR, 1'b1, eos, 1'b1});
    end else begin
      seq_point   = {seq_point[14:0], b[5:0]};
      seq_pending = seq_pending - 2'd1;
      if (seq_pending == 2'd0) begin
        emit_point(seq_point, eos);
        seq_point = 21'd0;
      end
    end
    // A string that ends with a sequence still open closes with one replacement.
    if (seq_pending != 2'd0 && eos) begin
      seq_pending = 2'd0;
      seq_point   = 21'd0;
      expected_units.push_back('{REPL_CHAR, 1'b1, 1'b1, 1'b1});
    end
  endfunction

  // Present one request at the falling edge, idling first at random, and
  // hold it until the rising edge that accepts it.
  task automatic send_byte(input logic [7:0] b, input logic eos, input logic typed,
                           input code_unit_t want);
    @(negedge clk);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    byte_in       <= b;
    end_of_string <= eos;
    row_typed = typed;
    row_want  = want;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  // Send one random sequence: mostly well-formed with random payload, the
  // rest raw noise or sequences cut short by a foreign byte or the string end.
  task automatic send_random_sequence();
    logic [7:0] seq [5];
    int         len;
    int         kind;
    logic       cut;
    logic       cut_at_end;
    logic       eos;
    kind       = $urandom_range(0, 99);
    len        = 1;
    cut        = 1'b0;
    cut_at_end = 1'b0;
    seq[0]     = 8'($urandom_range(0, 127));
    if (kind < 30) begin
      len = 1;
    end else if (kind < 50) begin
      seq[0] = 8'hC0 | 8'($urandom_range(0, 31));
      len    = 2;
    end else if (kind < 70) begin
      seq[0] = 8'hE0 | 8'($urandom_range(0, 15));
      len    = 3;
    end else if (kind < 85) begin
      seq[0] = 8'hF0 | 8'($urandom_range(0, 7));
      len    = 4;
    end else if (kind < 93) begin
      seq[0] = 8'($urandom_range(0, 255));
    end else begin
      seq[0] = 8'($urandom_range(8'hC0, 8'hF7));
      len    = 1 + $urandom_range(0, seq[0] >= 8'hF0 ? 2 : (seq[0] >= 8'hE0 ? 1 : 0));
      cut    = 1'b1;
    end
    for (int i = 1; i < len; i++) seq[i] = 8'h80 | 8'($urandom_range(0, 63));
    if (cut) begin
      if ($urandom_range(0, 1) == 1) begin
        seq[len] = $urandom_range(0, 1) ? 8'($urandom_range(0, 127))
                                        : 8'($urandom_range(8'hC0, 8'hFF));
        len++;
      end else begin
        cut_at_end = 1'b1;
      end
    end
    for (int i = 0; i < len; i++) begin
      if (i == len - 1) eos = cut_at_end || ($urandom_range(0, 9) == 0);
      else eos = ($urandom_range(0, 49) == 0);
      send_byte(seq[i], eos, 1'b0, '0);
    end
  endtask

  // Receiver: stall at random with the rate of the current phase.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < out_stall_pct);
  end

  // Scoreboard: predict on every accepted request, then check every accepted
  // unit against the oldest expectation.
  always @(posedge clk) begin : scoreboard
    int         depth;
    code_unit_t got;
    code_unit_t want;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        depth = expected_units.size();
        decode_byte(byte_in, end_of_string);
        if (row_typed) begin
          // Keep the model state, but trust the unit written in the table.
          while (expected_units.size() > depth) void'(expected_units.pop_back());
          expected_units.push_back(row_want);
        end
      end
      if (out_valid && !out_stall) begin
        got = '{code_unit, last_of_run, string_done, replaced};
        if (expected_units.size() == 0) begin
          failures++;
          if (failures <= ReportLimit)
            $display("unexpected unit %h last %b done %b repl %b",
                     got.unit, got.last, got.done, got.repl);
        end else begin
          want = expected_units.pop_front();
          if (got !== want) begin
            failures++;
            if (failures <= ReportLimit)
              $display("mismatch: expected unit %h last %b done %b repl %b, got %h %b %b %b",
                       want.unit, want.last, want.done, want.repl,
                       got.unit, got.last, got.done, got.repl);
          end
        end
      end
    end
  end

  // Watchdog: stop a hung run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("utf8_to_utf16_transcoder_unit_test NOT OK");
      $finish;
    end
  end

  initial begin
    int target;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // Directed walk under the first idling profile.
    foreach (directed_rows[i]) begin
      send_byte(directed_rows[i].b, directed_rows[i].eos, directed_rows[i].typed,
                '{directed_rows[i].unit, directed_rows[i].last,
                  directed_rows[i].done, directed_rows[i].repl});
    end

    // Random phases: light sender gaps with heavy back pressure, then the
    // reverse, then both sides at full rate.
    for (int phase = 0; phase < 3; phase++) begin
      in_idle_pct   = (phase == 0) ? 7 : ((phase == 1) ? 88 : 0);
      out_stall_pct = (phase == 0) ? 88 : ((phase == 1) ? 7 : 0);
      target = bytes_sent + BytesPerPhase;
      while (bytes_sent < target) send_random_sequence();
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_units.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (failures == 0) begin
      $display("utf8_to_utf16_transcoder_unit_test OK");
    end else begin
      $display("utf8_to_utf16_transcoder_unit_test NOT OK");
    end
    $finish;
  end

endmodule
